// ===== hw/rtl/mau_pkg.sv =====
// Package with the shared constants, types and modular helper functions.
`default_nettype none
package mau_pkg;

    localparam int VALUE_BITS = 31;
    localparam int EXP_BITS   = 63;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam logic [VALUE_BITS-1:0] RESET_MODULUS = VALUE_BITS'(1000000007);

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_MUL = 2'd1,
        MODE_DIV = 2'd2,
        MODE_POW = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DISPATCH,
        ST_MUL,
        ST_MUL_DONE,
        ST_EUC_CHK,
        ST_EUC_DIV,
        ST_EUC_UPD,
        ST_POW_CHK,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RET_RESULT,
        RET_PACC,
        RET_PBASE
    } t_ret;

    // (x + y) mod m for x, y below m.
    function automatic t_value add_mod(input t_value x, input t_value y, input t_value m);
        logic [VALUE_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[VALUE_BITS-1:0];
    endfunction

    // (x - y) mod m for x, y below m.
    function automatic t_value sub_mod(input t_value x, input t_value y, input t_value m);
        logic [VALUE_BITS:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (x < y) begin
            d = d + {1'b0, m};
        end
        return d[VALUE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Top level: modular add, multiply, divide and power with a bit-serial datapath.
// Each operation first reduces both operands mod m. Add then adds them, multiply runs one modular
// multiply, divide runs extended Euclid steps and then multiplies by the inverse, and power
// squares and multiplies over the exponent bits, lowest first, until the exponent is used up.
// Every multiply runs on one shared shift-and-add modular unit, one bit a cycle.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset clears control state and loads the default modulus.
`default_nettype none
module modular_arithmetic_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [mau_pkg::VALUE_BITS-1:0]    i_cfg_wr_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [mau_pkg::VALUE_BITS-1:0]    i_operand_a,
    input  wire logic [mau_pkg::VALUE_BITS-1:0]    i_operand_b,
    input  wire logic [mau_pkg::EXP_BITS-1:0]      i_exponent,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [mau_pkg::VALUE_BITS-1:0]         o_result,
    output logic                                   o_not_invertible
);

    localparam int VB = mau_pkg::VALUE_BITS;
    localparam int EB = mau_pkg::EXP_BITS;
    localparam int CW = mau_pkg::CNT_W;

    mau_pkg::t_state r_state, n_state;
    mau_pkg::t_ret   r_ret, n_ret;
    mau_pkg::t_mode  r_mode, n_mode;
    logic [CW-1:0]   r_cnt, n_cnt;
    mau_pkg::t_value r_m;
    mau_pkg::t_value r_a, n_a, r_b, n_b;
    mau_pkg::t_value r_ared, n_ared, r_bred, n_bred;
    logic [EB-1:0]   r_e, n_e;
    mau_pkg::t_value r_mx, n_mx, r_my, n_my, r_macc, n_macc;
    mau_pkg::t_value r_r0, n_r0, r_r1, n_r1, r_rem, n_rem;
    mau_pkg::t_value r_s0, n_s0, r_s1, n_s1;
    mau_pkg::t_value r_pacc, n_pacc, r_pbase, n_pbase;
    mau_pkg::t_value r_res, n_res;
    logic            r_flag, n_flag;
    logic            r_ovalid, n_ovalid;
    mau_pkg::t_value r_ores, n_ores;
    logic            r_oflag, n_oflag;

    logic [VB:0]     w_sh_a, w_sh_b, w_sh_r;
    mau_pkg::t_value w_one;

    assign o_in_ready       = (r_state == mau_pkg::ST_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_result         = r_ores;
    assign o_not_invertible = r_oflag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mau_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_m      <= mau_pkg::RESET_MODULUS;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_m <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_mode  <= n_mode;
        r_cnt   <= n_cnt;
        r_a     <= n_a;
        r_b     <= n_b;
        r_ared  <= n_ared;
        r_bred  <= n_bred;
        r_e     <= n_e;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_macc  <= n_macc;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_rem   <= n_rem;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
        r_pacc  <= n_pacc;
        r_pbase <= n_pbase;
        r_res   <= n_res;
        r_flag  <= n_flag;
        r_ores  <= n_ores;
        r_oflag <= n_oflag;
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_a      = r_a;
        n_b      = r_b;
        n_ared   = r_ared;
        n_bred   = r_bred;
        n_e      = r_e;
        n_mx     = r_mx;
        n_my     = r_my;
        n_macc   = r_macc;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_rem    = r_rem;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_pacc   = r_pacc;
        n_pbase  = r_pbase;
        n_res    = r_res;
        n_flag   = r_flag;
        n_ores   = r_ores;
        n_oflag  = r_oflag;
        n_ovalid = r_ovalid && !i_out_ready;

        // The constant one is zero when the modulus is one.
        w_one  = (r_m == VB'(1)) ? '0 : VB'(1);
        w_sh_a = {r_ared, r_a[VB-1]};
        w_sh_b = {r_bred, r_b[VB-1]};
        w_sh_r = {r_rem, r_r0[VB-1]};

        unique case (r_state)
            mau_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = mau_pkg::t_mode'(i_mode);
                    n_a     = i_operand_a;
                    n_b     = i_operand_b;
                    n_e     = i_exponent;
                    n_ared  = '0;
                    n_bred  = '0;
                    n_cnt   = CW'(VB - 1);
                    n_state = mau_pkg::ST_REDUCE;
                end
            end
            mau_pkg::ST_REDUCE: begin
                // Restoring reduction of both operands, one bit a cycle.
                n_ared = (w_sh_a >= {1'b0, r_m}) ? VB'(w_sh_a - {1'b0, r_m}) : VB'(w_sh_a);
                n_bred = (w_sh_b >= {1'b0, r_m}) ? VB'(w_sh_b - {1'b0, r_m}) : VB'(w_sh_b);
                n_a    = {r_a[VB-2:0], 1'b0};
                n_b    = {r_b[VB-2:0], 1'b0};
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = mau_pkg::ST_DISPATCH;
                end
            end
            mau_pkg::ST_DISPATCH: begin
                n_flag = 1'b0;
                if (r_m == '0) begin
                    n_res   = '0;
                    n_state = mau_pkg::ST_FINISH;
                end else begin
                    unique case (r_mode)
                        mau_pkg::MODE_ADD: begin
                            n_res   = mau_pkg::add_mod(r_ared, r_bred, r_m);
                            n_state = mau_pkg::ST_FINISH;
                        end
                        mau_pkg::MODE_MUL: begin
                            n_mx    = r_ared;
                            n_my    = r_bred;
                            n_macc  = '0;
                            n_cnt   = CW'(VB - 1);
                            n_ret   = mau_pkg::RET_RESULT;
                            n_state = mau_pkg::ST_MUL;
                        end
                        mau_pkg::MODE_DIV: begin
                            n_r0    = r_bred;
                            n_r1    = r_m;
                            n_s0    = w_one;
                            n_s1    = '0;
                            n_state = mau_pkg::ST_EUC_CHK;
                        end
                        mau_pkg::MODE_POW: begin
                            n_pacc  = w_one;
                            n_pbase = r_ared;
                            n_state = mau_pkg::ST_POW_CHK;
                        end
                        default: n_state = mau_pkg::ST_FINISH;
                    endcase
                end
            end
            mau_pkg::ST_MUL: begin
                // Horner over the multiplier bits, most significant first.
                n_macc = mau_pkg::add_mod(mau_pkg::add_mod(r_macc, r_macc, r_m),
                                          r_my[VB-1] ? r_mx : '0, r_m);
                n_my   = {r_my[VB-2:0], 1'b0};
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = mau_pkg::ST_MUL_DONE;
                end
            end
            mau_pkg::ST_MUL_DONE: begin
                unique case (r_ret)
                    mau_pkg::RET_RESULT: begin
                        n_res   = r_macc;
                        n_state = mau_pkg::ST_FINISH;
                    end
                    mau_pkg::RET_PACC: begin
                        n_pacc = r_macc;
                        if (r_e[EB-1:1] == '0) begin
                            n_e     = '0;
                            n_state = mau_pkg::ST_POW_CHK;
                        end else begin
                            n_mx    = r_pbase;
                            n_my    = r_pbase;
                            n_macc  = '0;
                            n_cnt   = CW'(VB - 1);
                            n_ret   = mau_pkg::RET_PBASE;
                            n_state = mau_pkg::ST_MUL;
                        end
                    end
                    mau_pkg::RET_PBASE: begin
                        n_pbase = r_macc;
                        n_e     = {1'b0, r_e[EB-1:1]};
                        n_state = mau_pkg::ST_POW_CHK;
                    end
                    default: n_state = mau_pkg::ST_FINISH;
                endcase
            end
            mau_pkg::ST_EUC_CHK: begin
                if (r_r1 == '0) begin
                    if (r_r0 != VB'(1)) begin
                        n_flag  = 1'b1;
                        n_res   = '0;
                        n_state = mau_pkg::ST_FINISH;
                    end else begin
                        n_mx    = r_ared;
                        n_my    = r_s0;
                        n_macc  = '0;
                        n_cnt   = CW'(VB - 1);
                        n_ret   = mau_pkg::RET_RESULT;
                        n_state = mau_pkg::ST_MUL;
                    end
                end else begin
                    n_rem   = '0;
                    n_macc  = '0;
                    n_cnt   = CW'(VB - 1);
                    n_state = mau_pkg::ST_EUC_DIV;
                end
            end
            mau_pkg::ST_EUC_DIV: begin
                // Quotient bits come out most significant first; q * s1 mod m
                // is built alongside them in the multiply accumulator.
                if (w_sh_r >= {1'b0, r_r1}) begin
                    n_rem  = VB'(w_sh_r - {1'b0, r_r1});
                    n_macc = mau_pkg::add_mod(mau_pkg::add_mod(r_macc, r_macc, r_m),
                                              r_s1, r_m);
                end else begin
                    n_rem  = VB'(w_sh_r);
                    n_macc = mau_pkg::add_mod(r_macc, r_macc, r_m);
                end
                n_r0  = {r_r0[VB-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = mau_pkg::ST_EUC_UPD;
                end
            end
            mau_pkg::ST_EUC_UPD: begin
                n_r0    = r_r1;
                n_r1    = r_rem;
                n_s0    = r_s1;
                n_s1    = mau_pkg::sub_mod(r_s0, r_macc, r_m);
                n_state = mau_pkg::ST_EUC_CHK;
            end
            mau_pkg::ST_POW_CHK: begin
                n_macc = '0;
                n_cnt  = CW'(VB - 1);
                if (r_e == '0) begin
                    n_res   = r_pacc;
                    n_state = mau_pkg::ST_FINISH;
                end else if (r_e[0]) begin
                    n_mx    = r_pacc;
                    n_my    = r_pbase;
                    n_ret   = mau_pkg::RET_PACC;
                    n_state = mau_pkg::ST_MUL;
                end else begin
                    n_mx    = r_pbase;
                    n_my    = r_pbase;
                    n_ret   = mau_pkg::RET_PBASE;
                    n_state = mau_pkg::ST_MUL;
                end
            end
            mau_pkg::ST_FINISH: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_oflag  = r_flag;
                    n_state  = mau_pkg::ST_IDLE;
                end
            end
            default: n_state = mau_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mau_checker.sv =====
// Port-level checker for the modular arithmetic unit and its bind statement.
`default_nettype none
module mau_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [mau_pkg::VALUE_BITS-1:0] o_result,
    input wire logic                           o_not_invertible
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result) && $stable(o_not_invertible))
        else $error("stalled result changed");

    // A failed inverse always reports a zero result.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_not_invertible |-> o_result == '0)
        else $error("not_invertible with nonzero result");

    // The unit leaves idle on an input transfer, so ready drops after it.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_result         (o_result),
    .o_not_invertible (o_not_invertible)
);
`default_nettype wire

// ===== tb/tb_modular_arithmetic_unit.sv =====
// Self-checking testbench for the modular arithmetic unit.
`default_nettype none
module tb_modular_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = mau_pkg::VALUE_BITS;
    localparam int EB = mau_pkg::EXP_BITS;

    typedef struct {
        logic [VB-1:0] result;
        logic          not_invertible;
    } t_answer;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [VB-1:0] i_cfg_wr_data = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [1:0]    i_mode = mau_pkg::MODE_ADD;
    logic [VB-1:0] i_operand_a = '0;
    logic [VB-1:0] i_operand_b = '0;
    logic [EB-1:0] i_exponent = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [VB-1:0] o_result;
    logic          o_not_invertible;

    logic [VB-1:0] cur_modulus;
    t_answer       pending_answers[$];
    int            error_count = 0;
    int            burst_left = 0;
    bit            stall_enable = 1'b1;

    modular_arithmetic_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .i_exponent       (i_exponent),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result         (o_result),
        .o_not_invertible (o_not_invertible)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        return (x * y) % m;
    endfunction

    // Extended Euclid on signed 64-bit values; returns 0 when the divisor has no inverse.
    function automatic bit find_inverse(logic [63:0] v, logic [63:0] m, output logic [63:0] inv);
        longint r0, r1, s0, s1, q, t;
        r0 = longint'(v); r1 = longint'(m); s0 = 1; s1 = 0;
        inv = '0;
        while (r1 != 0) begin
            q = r0 / r1;
            t = r0 - q * r1; r0 = r1; r1 = t;
            t = s0 - q * s1; s0 = s1; s1 = t;
        end
        if (r0 != 1) return (m == 64'd1);
        t = s0 % longint'(m);
        if (t < 0) t += longint'(m);
        inv = 64'(t);
        return 1'b1;
    endfunction

    function automatic t_answer compute_answer(mau_pkg::t_mode mode, logic [VB-1:0] a_in,
                                               logic [VB-1:0] b_in, logic [EB-1:0] e_in);
        t_answer ans;
        logic [63:0] m, a, b, e, inv, acc;
        ans.result = '0;
        ans.not_invertible = 1'b0;
        m = 64'(cur_modulus);
        if (m == 64'd0) return ans;
        a = 64'(a_in) % m;
        b = 64'(b_in) % m;
        e = 64'(e_in);
        case (mode)
            mau_pkg::MODE_ADD: ans.result = VB'((a + b) % m);
            mau_pkg::MODE_MUL: ans.result = VB'(mulmod(a, b, m));
            mau_pkg::MODE_DIV: begin
                if (find_inverse(b, m, inv)) ans.result = VB'(mulmod(a, inv, m));
                else ans.not_invertible = 1'b1;
            end
            default: begin
                acc = 64'd1 % m;
                while (e != 64'd0) begin
                    if (e[0]) acc = mulmod(acc, a, m);
                    a = mulmod(a, a, m);
                    e = e >> 1;
                end
                ans.result = VB'(acc);
            end
        endcase
        return ans;
    endfunction

    // Within a burst, valid stays high and the next payload follows right after a transfer.
    task automatic send_operation(mau_pkg::t_mode mode, logic [VB-1:0] a,
                                  logic [VB-1:0] b, logic [EB-1:0] e);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_mode <= mode; i_operand_a <= a; i_operand_b <= b; i_exponent <= e;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers.push_back(compute_answer(mode, a, b, e));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_modulus(logic [VB-1:0] value);
        drain_results();
        i_cfg_wr_data <= value;
        i_cfg_wr_en <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_modulus = value;
    endtask

    function automatic logic [VB-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return VB'($urandom_range(0, 20));
            1: return {VB{1'b1}} - VB'($urandom_range(0, 5));
            default: return VB'($urandom);
        endcase
    endfunction

    function automatic logic [EB-1:0] rand_exponent();
        logic [EB-1:0] e;
        e = EB'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: return EB'($urandom_range(0, 40));
            1: return e >> $urandom_range(0, 62);
            default: return e;
        endcase
    endfunction

    task automatic test_directed();
        logic [VB-1:0] mx;
        mx = '1;
        send_operation(mau_pkg::MODE_ADD, '0, '0, '0);
        send_operation(mau_pkg::MODE_ADD, mx, mx, '0);
        send_operation(mau_pkg::MODE_MUL, mx, mx - VB'(1), '0);
        send_operation(mau_pkg::MODE_MUL, VB'(1000000006), VB'(1000000006), '0);
        send_operation(mau_pkg::MODE_DIV, VB'(10), VB'(3), '0);
        send_operation(mau_pkg::MODE_DIV, VB'(5), '0, '0);
        send_operation(mau_pkg::MODE_DIV, VB'(5), VB'(1000000007), '0);
        send_operation(mau_pkg::MODE_DIV, mx, mx, '0);
        send_operation(mau_pkg::MODE_POW, VB'(2), '0, '0);
        send_operation(mau_pkg::MODE_POW, '0, '0, '0);
        send_operation(mau_pkg::MODE_POW, mx, mx, '1);
        send_operation(mau_pkg::MODE_POW, VB'(3), '0, EB'(1000000006));
    endtask

    // Small moduli make non-invertible divisors common; the zero and one cases are degenerate.
    task automatic test_special_moduli();
        write_modulus('0);
        for (int i = 0; i < 4; i++)
            send_operation(mau_pkg::t_mode'(i), VB'(7), VB'(3), EB'(5));
        write_modulus(VB'(1));
        for (int i = 0; i < 4; i++)
            send_operation(mau_pkg::t_mode'(i), VB'(7), VB'(3), EB'(5));
        write_modulus(VB'(12));
        for (int i = 0; i < 8; i++) send_operation(mau_pkg::MODE_DIV, VB'(5), VB'(i), '0);
        write_modulus('1);
        send_operation(mau_pkg::MODE_DIV, VB'(123), '1, '0);
        send_operation(mau_pkg::MODE_POW, {VB{1'b1}} - VB'(1), '0, '1);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_operation(mau_pkg::t_mode'($urandom_range(0, 3)), rand_value(), rand_value(),
                           rand_exponent());
        end
    endtask

    task automatic test_random_moduli();
        logic [VB-1:0] mods[6];
        mods = '{VB'(2), VB'(97), VB'(65536), VB'(2147483629), VB'(1000000007), '1};
        foreach (mods[k]) begin
            write_modulus(mods[k]);
            test_random(70);
        end
        write_modulus(VB'($urandom));
        test_random(60);
    endtask

    // The receiver stalls at random, with periodic windows that never stall, and never while stall_enable is clear.
    always @(negedge i_clk) begin
        if (!stall_enable) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 9) < 6) || ($time % 3000 < 400);
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result %0d", o_result);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_result !== want.result) begin
                    $error("result expected %0d actual %0d", want.result, o_result);
                    error_count++;
                end
                if (o_not_invertible !== want.not_invertible) begin
                    $error("not_invertible expected %0d actual %0d", want.not_invertible,
                           o_not_invertible);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cur_modulus = mau_pkg::RESET_MODULUS;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_special_moduli();
        stall_enable = 1'b0;
        test_random(40);
        stall_enable = 1'b1;
        test_random_moduli();
        drain_results();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/mau_pkg.sv
hw/rtl/modular_arithmetic_unit.sv
hw/rtl/mau_checker.sv
tb/tb_modular_arithmetic_unit.sv
